@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication on one clock edge, reset masked.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication onto the next clock edge, reset masked.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/sacf_pkg.sv @@
// Shared types and constants of the set-associative cache tag controller.
package sacf_pkg;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_FETCH = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	localparam logic [31:0] FETCH_SKIP_ADDR = 32'hFFFF_FFFF;

	localparam int ADDR_W      = 32;
	localparam int SET_OUT_W   = 10;
	localparam int WAY_OUT_W   = 2;
	localparam int DIRTY_OUT_W = 13;

endpackage

@@ hw/rtl/set_assoc_cache_fifo_tags.sv @@
// Top level of the set-associative cache tag and state controller.
// Tag and state controller of a write-back, write-allocate, set-associative cache
// with FIFO replacement (4 ways, 1024 sets, 8-byte lines by default). Each request
// gives a kind (read, write, fetch) and a byte address and produces one result:
// hit, the way used, whether a dirty line was evicted, and the running count of
// dirty lines. A fetch of all ones, and kind 3, change nothing and report ignored.
// Each request first reads the set's row from the tag RAM and the state RAM
// (registered read), then resolves and writes the row back, which waits while a
// stalled result is held; the next request is taken after that. After reset a
// clearing pass over all SETS sets (1024 by default) zeroes the valid, dirty and
// oldest-way state; requests are held off until it ends. The result sits in an
// output register, so a new request is taken while the previous result waits.
// SETS and BLOCK_BYTES must be powers of two; the block does not enforce it.
module set_assoc_cache_fifo_tags #(
	parameter int SETS        = 1024,
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 8,
	parameter int ADDR_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ignored,
	output logic        hit,
	output logic        wrote_back,
	output logic [9:0]  set_index,
	output logic [1:0]  way_used,
	output logic [12:0] dirty_lines
);

	localparam int AW     = (ADDR_BITS < sacf_pkg::ADDR_W) ? ADDR_BITS : sacf_pkg::ADDR_W;
	localparam int OFF_W  = $clog2(BLOCK_BYTES);
	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int TAG_RAW = AW - OFF_W - SET_W;
	localparam int TAG_W  = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int XW     = AW + OFF_W + SET_W + TAG_W;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W  = $clog2(SETS * WAYS + 1);
	localparam int META_W = 2 * WAYS + WAY_W;
	localparam int ROW_W  = WAYS * TAG_W;

	sacf_pkg::state_t state_q, state_d;

	logic [SET_W-1:0]  clr_q;
	logic [CNT_W-1:0]  cnt_q, cnt_new;

	logic [TAG_W-1:0]  tag_s1;
	logic [SET_W-1:0]  set_s1;
	logic              ign_s1;
	logic              wr_s1;

	logic              out_valid_q;
	logic              ignored_q, hit_q, wb_q;
	logic [9:0]        set_q;
	logic [1:0]        way_q;
	logic [12:0]       dirty_q;

	logic [XW-1:0]     addr_x;
	logic [SET_W-1:0]  in_set;
	logic [TAG_W-1:0]  in_tag;
	logic              in_ign;
	logic              accept;
	logic              done;
	logic              clearing;

	logic              meta_we, tag_we;
	logic [SET_W-1:0]  meta_waddr;
	logic [META_W-1:0] meta_wdata, meta_rd;
	logic [ROW_W-1:0]  row_rd, row_wr;

	logic [WAYS-1:0]   valid_v, dirty_v, valid_n, dirty_n, victim_oh;
	logic [WAY_W-1:0]  oldest, oldest_n, hit_way, free_way, victim;
	logic              hit_f, free_f, full, wb_f, cnt_inc, cnt_dec;
	logic [WAY_W+1:0]  way_x;
	logic [SET_W+9:0]  set_x;
	logic [CNT_W+12:0] cnt_x;

	assign addr_x = {{(XW - AW){1'b0}}, address[AW-1:0]};
	assign in_set = addr_x[OFF_W +: SET_W];
	assign in_tag = addr_x[OFF_W + SET_W +: TAG_W];
	assign in_ign = (kind == sacf_pkg::KIND_NONE) ||
		((kind == sacf_pkg::KIND_FETCH) && (address == sacf_pkg::FETCH_SKIP_ADDR));

	assign accept = in_valid && !in_stall;
	assign done   = (state_q == sacf_pkg::ST_LOOKUP) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sacf_pkg::ST_CLEAR: begin
				if (clr_q == SET_W'(SETS - 1)) begin
					state_d = sacf_pkg::ST_IDLE;
				end
			end
			sacf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sacf_pkg::ST_LOOKUP;
				end
			end
			sacf_pkg::ST_LOOKUP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = sacf_pkg::ST_IDLE;
				end
			end
			default: state_d = sacf_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		clearing = 1'b0;
		unique case (state_q)
			sacf_pkg::ST_CLEAR:  clearing = 1'b1;
			sacf_pkg::ST_IDLE:   in_stall = 1'b0;
			sacf_pkg::ST_LOOKUP: in_stall = 1'b1;
			default:             in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacf_pkg::ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (done) begin
				cnt_q       <= cnt_new;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= in_tag;
			set_s1 <= in_set;
			ign_s1 <= in_ign;
			wr_s1  <= (kind == sacf_pkg::KIND_WRITE);
		end
		if (done) begin
			ignored_q <= ign_s1;
			hit_q     <= !ign_s1 && hit_f;
			wb_q      <= !ign_s1 && wb_f;
			set_q     <= ign_s1 ? '0 : set_x[9:0];
			way_q     <= ign_s1 ? '0 : way_x[1:0];
			dirty_q   <= cnt_x[12:0];
		end
	end

	// resolve the set read when the request was taken
	always_comb begin
		valid_v  = meta_rd[WAYS-1:0];
		dirty_v  = meta_rd[2*WAYS-1:WAYS];
		oldest   = meta_rd[2*WAYS +: WAY_W];
		hit_f    = 1'b0;
		hit_way  = '0;
		free_f   = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid_v[w] && (row_rd[w*TAG_W +: TAG_W] == tag_s1)) begin
				hit_f   = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!valid_v[w]) begin
				free_f   = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		full   = !free_f;
		victim = hit_f ? hit_way : (free_f ? free_way : oldest);
		for (int w = 0; w < WAYS; w++) begin
			victim_oh[w] = (victim == WAY_W'(w));
			row_wr[w*TAG_W +: TAG_W] = victim_oh[w] ? tag_s1 : row_rd[w*TAG_W +: TAG_W];
		end
		wb_f    = !hit_f && full && dirty_v[victim];
		valid_n = valid_v | victim_oh;
		if (hit_f) begin
			dirty_n = wr_s1 ? (dirty_v | victim_oh) : dirty_v;
		end else begin
			dirty_n = wr_s1 ? (dirty_v | victim_oh) : (dirty_v & ~victim_oh);
		end
		if (!hit_f && full) begin
			oldest_n = (oldest == WAY_W'(WAYS - 1)) ? '0 : oldest + WAY_W'(1);
		end else begin
			oldest_n = oldest;
		end
		cnt_inc = !ign_s1 && wr_s1 && (!hit_f || !dirty_v[victim]);
		cnt_dec = !ign_s1 && wb_f && (cnt_q != '0);
		cnt_new = cnt_q + CNT_W'(cnt_inc) - CNT_W'(cnt_dec);
		way_x   = {2'b00, victim};
		set_x   = {10'b0, set_s1};
		cnt_x   = {13'b0, cnt_new};
	end

	assign meta_we    = clearing || (done && !ign_s1);
	assign meta_waddr = clearing ? clr_q : set_s1;
	assign meta_wdata = clearing ? '0 : {oldest_n, dirty_n, valid_n};
	assign tag_we     = done && !ign_s1 && !hit_f;

	sacf_ram #(
		.WIDTH(META_W),
		.DEPTH(SETS)
	) u_meta_ram (
		.clk    (clk),
		.wr_en  (meta_we),
		.wr_addr(meta_waddr),
		.wr_data(meta_wdata),
		.rd_en  (accept),
		.rd_addr(in_set),
		.rd_data(meta_rd)
	);

	sacf_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SETS)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (tag_we),
		.wr_addr(set_s1),
		.wr_data(row_wr),
		.rd_en  (accept),
		.rd_addr(in_set),
		.rd_data(row_rd)
	);

	assign out_valid   = out_valid_q;
	assign ignored     = ignored_q;
	assign hit         = hit_q;
	assign wrote_back  = wb_q;
	assign set_index   = set_q;
	assign way_used    = way_q;
	assign dirty_lines = dirty_q;

endmodule

@@ hw/rtl/sacf_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sacf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/sacf_checker.sv @@
// Port-level checker of the cache tag controller, bound to the top level.
`include "assert_macros.svh"

module sacf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        ignored,
	input logic        hit,
	input logic        wrote_back,
	input logic [9:0]  set_index,
	input logic [1:0]  way_used,
	input logic [12:0] dirty_lines
);

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(wrote_back) && $stable(dirty_lines) && $stable(way_used), "stalled result changed")

	`ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken while previous one in flight")

	`ASSERT_IMPL(a_ignored_clean, out_valid && ignored, !hit && !wrote_back && (set_index == 10'd0) && (way_used == 2'd0), "ignored request reports activity")

	`ASSERT_IMPL(a_hit_no_wb, out_valid && (hit || ignored), !wrote_back, "write-back on hit or ignored request")

endmodule

bind set_assoc_cache_fifo_tags sacf_checker u_sacf_checker (.*);
